// ----- design/sobel_pkg.sv -----
// shared types, constants and helpers of the rgb sobel edge stream
`default_nettype none

package sobel_pkg;

    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int MAX_HEIGHT      = 4096;
    localparam int MIN_DIM         = 3;
    localparam int FW_W            = 12;
    localparam int FH_W            = 13;
    localparam int ROW_W           = 12;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 13;
    localparam int PIX_W           = 24;
    localparam int EDGE_MAX        = 255;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] pix_red;
        logic [7:0] pix_green;
        logic [7:0] pix_blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] edge_level;
        logic       frame_done;
    } t_edge_out;

    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        logic [7:0] trow;
        logic [7:0] brow;
        logic [7:0] lcol;
        logic [7:0] rcol;
    } t_wsum;

    typedef t_wsum [2:0] t_wsum_set;

    typedef struct packed {
        logic valid;
        logic has_res;
        logic frame_done;
    } t_stage_ctl;

    function automatic logic [7:0] f_wsum(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
        logic [9:0] s;
        s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
        return s[9:2];
    endfunction

    function automatic logic [7:0] f_absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ----- design/sobel_edge_rgb_stream.sv -----
// top level of the rgb sobel edge stream
// usage:
//   pixels enter in raster order on i_pix with i_pix_valid / o_pix_stall; a
//   transfer happens on a clock edge with valid high and stall low
//   edge bytes leave on o_edge with o_edge_valid / i_edge_stall, one for each
//   interior pixel, sent when the pixel right-below it has been taken in
//   o_edge.frame_done marks the last interior result of a frame
//   throughput: one pixel per clock while the input does not stall; the line
//   ram is read and written once per pixel on separate ports, and the column
//   pitch of at least three keeps a read from meeting a pending write
//   a result passes the line ram read, the window sums register and the
//   output register after the transfer of the pixel that completes its window
//   when the receiver stalls, pixels without a result keep flowing; the
//   input stalls only when a new result would land on a held one
//   reset: sync, active low; geometry back to 640x480, position to the first
//   pixel, no ram clearing; a width or height write restarts the frame position
//   config writes must be made only while the pipeline is empty; the block does not enforce it
`default_nettype none

module sobel_edge_rgb_stream #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_pix_valid,
    output      logic                                o_pix_stall,
    input  wire sobel_pkg::t_pix_in                  i_pix,
    output      logic                                o_edge_valid,
    input  wire logic                                i_edge_stall,
    output      sobel_pkg::t_edge_out                o_edge,
    input  wire logic                                i_cfg_we,
    input  wire logic [sobel_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sobel_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import sobel_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEFF_W = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
    localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);

    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    logic [WEFF_W-1:0] w_eff;
    logic [HEFF_W-1:0] h_eff;
    logic [COL_W-1:0]  last_col;
    logic [ROW_W-1:0]  last_row;
    logic              at_last_col;
    logic              at_last_row;

    logic              adv;
    logic              accept;

    t_stage_ctl        r_s1_ctl;
    logic [COL_W-1:0]  r_s1_addr;
    t_rgb              r_s1_cur;
    t_stage_ctl        s2_ctl;
    t_wsum_set         s2_sums;

    logic [2*PIX_W-1:0] ram_rdata;
    logic [COL_W-1:0]   ram_raddr;
    t_rgb               top;
    t_rgb               mid;

    // effective geometry
    always_comb begin
        if (r_frame_width < FW_W'(MIN_DIM)) begin
            w_eff = WEFF_W'(MIN_DIM);
        end else if (WEFF_W'(r_frame_width) > WEFF_W'(MAX_WIDTH)) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(r_frame_width);
        end
        if (r_frame_height < FH_W'(MIN_DIM)) begin
            h_eff = HEFF_W'(MIN_DIM);
        end else if (r_frame_height > FH_W'(MAX_HEIGHT)) begin
            h_eff = HEFF_W'(MAX_HEIGHT);
        end else begin
            h_eff = HEFF_W'(r_frame_height);
        end
    end

    logic [WEFF_W-1:0] w_last_full;
    logic [HEFF_W-1:0] h_last_full;
    assign w_last_full = w_eff - WEFF_W'(1);
    assign h_last_full = h_eff - HEFF_W'(1);
    assign last_col    = w_last_full[COL_W-1:0];
    assign last_row    = h_last_full[ROW_W-1:0];
    assign at_last_col = (r_col == last_col);
    assign at_last_row = (r_row == last_row);

    // pipeline moves unless a new result would overwrite a held one
    assign adv         = !(o_edge_valid && i_edge_stall && s2_ctl.valid && s2_ctl.has_res);
    assign o_pix_stall = !adv;
    assign accept      = i_pix_valid && adv;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (at_last_col) begin
                n_col = '0;
                n_row = at_last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FW_W-1:0];
                    r_col         <= '0;
                    r_row         <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FH_W-1:0];
                    r_col          <= '0;
                    r_row          <= '0;
                end
                default: begin
                    r_col <= n_col;
                    r_row <= n_row;
                end
            endcase
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line ram read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (adv) begin
            r_s1_ctl.valid      <= accept;
            r_s1_ctl.has_res    <= accept && (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
            r_s1_ctl.frame_done <= accept && at_last_col && at_last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= r_col;
            r_s1_cur  <= t_rgb'(i_pix);
        end
    end

    // hold the read address while frozen so the read data stays put
    assign ram_raddr = adv ? r_col : r_s1_addr;
    assign top       = t_rgb'(ram_rdata[2*PIX_W-1:PIX_W]);
    assign mid       = t_rgb'(ram_rdata[PIX_W-1:0]);

    sobel_ram #(
        .P_WIDTH (2 * PIX_W),
        .P_DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (adv && r_s1_ctl.valid),
        .i_waddr (r_s1_addr),
        .i_wdata ({mid, r_s1_cur}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sobel_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (r_s1_ctl),
        .i_top   (top),
        .i_mid   (mid),
        .i_cur   (r_s1_cur),
        .o_ctl   (s2_ctl),
        .o_sums  (s2_sums)
    );

    sobel_grad u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (s2_ctl),
        .i_sums  (s2_sums),
        .i_stall (i_edge_stall),
        .o_valid (o_edge_valid),
        .o_edge  (o_edge)
    );

endmodule

`default_nettype wire

// ----- design/sobel_ram.sv -----
// generic simple dual port ram with registered read
`default_nettype none

module sobel_ram #(
    parameter int P_WIDTH = 48,
    parameter int P_DEPTH = 2048
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output      logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/sobel_window.sv -----
// 3x3 window shift registers and per-channel 1-2-1 row and column sums
`default_nettype none

module sobel_window (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire sobel_pkg::t_stage_ctl i_ctl,
    input  wire sobel_pkg::t_rgb       i_top,
    input  wire sobel_pkg::t_rgb       i_mid,
    input  wire sobel_pkg::t_rgb       i_cur,
    output      sobel_pkg::t_stage_ctl o_ctl,
    output      sobel_pkg::t_wsum_set  o_sums
);

    import sobel_pkg::*;

    t_rgb      r_win [6];
    t_wsum_set n_sums;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sums[c].trow = f_wsum(r_win[0][c], r_win[3][c], i_top[c]);
            n_sums[c].brow = f_wsum(r_win[2][c], r_win[5][c], i_cur[c]);
            n_sums[c].lcol = f_wsum(r_win[0][c], r_win[1][c], r_win[2][c]);
            n_sums[c].rcol = f_wsum(i_top[c], i_mid[c], i_cur[c]);
        end
    end

    // window shift, one column per transfer
    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= i_top;
            r_win[4] <= i_mid;
            r_win[5] <= i_cur;
            o_sums   <= n_sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_adv) begin
            o_ctl <= i_ctl;
        end
    end

endmodule

`default_nettype wire

// ----- design/sobel_grad.sv -----
// gradient magnitude, scaling, saturation and output register
`default_nettype none

module sobel_grad (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire sobel_pkg::t_stage_ctl i_ctl,
    input  wire sobel_pkg::t_wsum_set  i_sums,
    input  wire logic                  i_stall,
    output      logic                  o_valid,
    output      sobel_pkg::t_edge_out  o_edge
);

    import sobel_pkg::*;

    logic [10:0] total;
    logic [8:0]  scaled;
    logic [7:0]  n_level;

    always_comb begin
        total = '0;
        for (int c = 0; c < 3; c++) begin
            total = total + {3'b000, f_absdiff(i_sums[c].trow, i_sums[c].brow)}
                          + {3'b000, f_absdiff(i_sums[c].lcol, i_sums[c].rcol)};
        end
        scaled  = total[10:2];
        n_level = (scaled > 9'(EDGE_MAX)) ? 8'(EDGE_MAX) : scaled[7:0];
    end

    logic load;
    assign load = i_adv && i_ctl.valid && i_ctl.has_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_edge.edge_level <= n_level;
            o_edge.frame_done <= i_ctl.frame_done;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_sobel_edge_rgb_stream.sv -----
// testbench for the rgb sobel edge stream: predicts edge bytes and checks every transfer
`timescale 1ns / 100ps

module tb_sobel_edge_rgb_stream;

    import sobel_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 850;
    localparam int LIMIT_NS     = 8_000_000;

    class sobel_predictor;
        t_edge_out                 edges_due[$];
        int                        errors;
        int                        edges_checked;
        int                        frames_done;
        logic [FW_W-1:0]           width_reg;
        logic [FH_W-1:0]           height_reg;
        logic [PIX_W-1:0]          line_old [MAX_WIDTH_DEF];
        logic [PIX_W-1:0]          line_new [MAX_WIDTH_DEF];
        logic [PIX_W-1:0]          win [6];
        int unsigned               col;
        int unsigned               row;

        function new();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            foreach (line_old[i]) begin
                line_old[i] = '0;
                line_new[i] = '0;
            end
            foreach (win[i]) begin
                win[i] = '0;
            end
            col = 0;
            row = 0;
            errors = 0;
            edges_checked = 0;
            frames_done = 0;
        endfunction

        function int pending();
            return edges_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FRAME_WIDTH) begin
                width_reg = data[FW_W-1:0];
            end else if (idx == CFG_FRAME_HEIGHT) begin
                height_reg = data;
            end else begin
                return;
            end
            col = 0;
            row = 0;
        endfunction

        // (a + 2b + c) / 4 on one channel, channel 0 is red
        function int unsigned tap_sum(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                      logic [PIX_W-1:0] c, int ch);
            int unsigned s;
            s = a[(2-ch)*8 +: 8] + 2 * b[(2-ch)*8 +: 8] + c[(2-ch)*8 +: 8];
            return s / 4;
        endfunction

        function int unsigned gap(int unsigned a, int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void note_pixel(t_pix_in p);
            int unsigned w, h, x, y, total;
            int ch;
            logic [PIX_W-1:0] cur, up, mid;
            t_edge_out e;
            w = width_reg;
            if (w < MIN_DIM) w = MIN_DIM;
            if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            h = height_reg;
            if (h < MIN_DIM) h = MIN_DIM;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            x = col;
            y = row;
            cur = p;
            up = line_old[x];
            mid = line_new[x];
            if (x >= 2 && y >= 2) begin
                total = 0;
                for (ch = 0; ch < 3; ch++) begin
                    total += gap(tap_sum(win[0], win[3], up, ch), tap_sum(win[2], win[5], cur, ch));
                    total += gap(tap_sum(win[0], win[1], win[2], ch), tap_sum(up, mid, cur, ch));
                end
                total = total / 4;
                if (total > EDGE_MAX) total = EDGE_MAX;
                e.edge_level = total[7:0];
                e.frame_done = (x + 1 >= w) && (y + 1 >= h);
                edges_due.push_back(e);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = up;
            win[4] = mid;
            win[5] = cur;
            line_old[x] = mid;
            line_new[x] = cur;
            if (x + 1 >= w) begin
                col = 0;
                if (y + 1 >= h) begin
                    row = 0;
                    frames_done++;
                end else begin
                    row = y + 1;
                end
            end else begin
                col = x + 1;
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 40) begin
                $display("mismatch: %s", what);
            end
        endtask

        task check_edge(t_edge_out got);
            t_edge_out want;
            if (edges_due.size() == 0) begin
                report_mismatch($sformatf("edge transfer %0h/%0b with nothing predicted",
                                          got.edge_level, got.frame_done));
                return;
            end
            want = edges_due.pop_front();
            edges_checked++;
            if (got.edge_level !== want.edge_level) begin
                report_mismatch($sformatf("result %0d edge_level %0d, predicted %0d",
                                          edges_checked, got.edge_level, want.edge_level));
            end
            if (got.frame_done !== want.frame_done) begin
                report_mismatch($sformatf("result %0d frame_done %0b, predicted %0b",
                                          edges_checked, got.frame_done, want.frame_done));
            end
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_pix_valid;
    logic                   o_pix_stall;
    t_pix_in                i_pix;
    logic                   o_edge_valid;
    logic                   i_edge_stall;
    t_edge_out              o_edge;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    sobel_predictor board;
    bit  idle_on;
    bit  hold_rx;
    int  rx_gap;
    int  pixels_sent;
    int  in_stall_cycles;

    sobel_edge_rgb_stream uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_pix_valid),
        .o_pix_stall  (o_pix_stall),
        .i_pix        (i_pix),
        .o_edge_valid (o_edge_valid),
        .i_edge_stall (i_edge_stall),
        .o_edge       (o_edge),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // result side: check each transfer, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_gap = 0;
            in_stall_cycles = 0;
            i_edge_stall <= 1'b0;
        end else begin
            if (o_edge_valid && !i_edge_stall) begin
                board.check_edge(o_edge);
            end
            if (i_pix_valid && o_pix_stall) begin
                in_stall_cycles++;
            end
            if (rx_gap > 0) begin
                rx_gap--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(1, 12);
            end
            i_edge_stall <= hold_rx || (rx_gap > 0);
        end
    end

    function t_pix_in rand_pixel();
        logic [31:0] r;
        t_pix_in p;
        r = $urandom();
        p = r[PIX_W-1:0];
        if ($urandom_range(0, 3) == 0) begin
            p.pix_red   = r[24] ? 8'hFF : 8'h00;
            p.pix_green = r[25] ? 8'hFF : 8'h00;
            p.pix_blue  = r[26] ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    function t_pix_in probe_pixel(int kind, int x, int y);
        t_pix_in p;
        if (kind == 0) begin
            p = (x == 0 || y == 0) ? 24'hFFFFFF : 24'h000000;
        end else begin
            p = ((x + y) % 2 == 1) ? 24'hFF00FF : 24'h00FF00;
        end
        return p;
    endfunction

    task send_pixel(t_pix_in p);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_pix_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_pix_valid <= 1'b1;
        i_pix <= p;
        do begin
            @(posedge i_clk);
        end while (o_pix_stall);
        board.note_pixel(p);
        pixels_sent++;
    endtask

    task send_run(int count);
        int i;
        for (i = 0; i < count; i++) begin
            send_pixel(rand_pixel());
        end
    endtask

    task send_probe_frame(int kind);
        int x, y;
        for (y = 0; y < 3; y++) begin
            for (x = 0; x < 3; x++) begin
                send_pixel(probe_pixel(kind, x, y));
            end
        end
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_pix_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, data);
    endtask

    task configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    task hold_receiver(int cycles);
        hold_rx <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_rx <= 1'b0;
    endtask

    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int w, h, w_raw, h_raw, n, k, base;
        logic [CFG_IDX_W-1:0] spare;
        board = new();
        idle_on = 1'b1;
        pixels_sent = 0;
        hold_rx <= 1'b0;
        i_rst_n <= 1'b0;
        i_pix_valid <= 1'b0;
        i_pix <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_FRAME_WIDTH;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry, part of the first row
        send_run(40);

        // clamped low sizes, then a width with the spare top bit set
        configure(13'd0, 13'd2);
        send_probe_frame(0);
        configure(13'h1003, 13'd3);
        send_probe_frame(1);

        base = pixels_sent;
        while (pixels_sent - base < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 48) : $urandom_range(3, 10);
            h = $urandom_range(3, 8);
            w_raw = (w == 3 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : w;
            h_raw = (h == 3 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : h;
            configure(CFG_DATA_W'(w_raw), CFG_DATA_W'(h_raw));
            n = $urandom_range(1, 3) * w * h;
            if ($urandom_range(0, 3) == 0) begin
                n += $urandom_range(1, 2 * w);
            end
            if ($urandom_range(0, 3) == 0) begin
                // write to a register index that does not exist, mid frame
                k = $urandom_range(1, n - 1);
                spare = ($urandom_range(0, 1) == 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI;
                send_run(k);
                write_reg(spare, CFG_DATA_W'($urandom_range(0, 8191)));
                send_run(n - k);
            end else begin
                send_run(n);
            end
        end

        // widest rows, width clamped from the largest register value, first row only
        configure(13'h1FFF, 13'd3);
        send_run(40);
        configure(13'd2048, 13'd3);
        send_run(40);
        // tallest frames, partial only
        configure(13'd3, 13'h1FFF);
        send_run(60);
        configure(13'd4, 13'd4096);
        send_run(40);

        // receiver holds off while pixels keep coming
        configure(13'd6, 13'd50);
        fork
            hold_receiver(400);
            send_run(250);
        join

        idle_on = 1'b0;
        configure(13'd7, 13'd5);
        send_run(3 * 35);

        i_pix_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d pixels in, %0d edge results checked, %0d frames completed",
                 pixels_sent, board.edges_checked, board.frames_done);
        $display("summary: %0d cycles of input stall seen, %0d mismatches",
                 in_stall_cycles, board.errors);
        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/sobel_pkg.sv
design/sobel_ram.sv
design/sobel_window.sv
design/sobel_grad.sv
design/sobel_edge_rgb_stream.sv
tb/sv/tb_sobel_edge_rgb_stream.sv
